@@ sv/bsd_pkg.sv @@
package bsd_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_DEGREE  = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned SUM_BITS    = 24;

  // configuration register widths
  localparam int unsigned WIDTH_BITS  = 11;
  localparam int unsigned DEGREE_BITS = 3;

  // position counters and line memory address
  localparam int unsigned POS_BITS    = $clog2(MAX_WIDTH);

  localparam int unsigned PADDR_BITS  = 3;
  localparam int unsigned PDATA_BITS  = 32;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(64);
  localparam logic [DEGREE_BITS-1:0] DEGREE_RESET = DEGREE_BITS'(1);

  // register select, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_BLOCK_DEGREE = 1'b1
  } bsd_reg_e;

endpackage

@@ sv/block_sum_downsampler.sv @@
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+--------------------------------
// in        | input     | in_valid_i / in_ready_o | sample_i[15:0], frame_start_i
// out       | output    | out_valid_o/ out_ready_i| block_sum_o[23:0], frame_last_o
// config    | input     | APB, pready tied high   | paddr[2:0], pwdata/prdata[31:0]
//
// One pixel is taken every cycle while the input is not stalled. A pixel that completes
// a block passes from the stage 1 register into the output register, where its sum
// shows once the output register is free.
// The rate is set by the read-modify-write of the partial sum line, a single
// 1024 x 24 memory with a registered read; the write of the previous pixel is
// forwarded to the next read of the same entry.
// Reset clears position counters, configuration registers and valid flags; the line
// memory is not cleared, since the first row of every band overwrites it.
// A held output stalls the input only when the pixel in the accumulate stage
// itself completes a block.
module block_sum_downsampler
  import bsd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   frame_start_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SUM_BITS-1:0]    block_sum_o,
  output logic                   frame_last_o,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_BITS-1:0]  paddr,
  input  logic [PDATA_BITS-1:0]  pwdata,
  output logic [PDATA_BITS-1:0]  prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  image_width_q;
  logic [DEGREE_BITS-1:0] block_degree_q;
  logic                   cfg_wr;
  bsd_reg_e               reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = bsd_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      block_degree_q <= DEGREE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[WIDTH_BITS-1:0];
        REG_BLOCK_DEGREE: block_degree_q <= pwdata[DEGREE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(image_width_q);
      REG_BLOCK_DEGREE: prdata = PDATA_BITS'(block_degree_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp to the supported range
  logic [WIDTH_BITS-1:0]  eff_width;
  logic [DEGREE_BITS-1:0] eff_degree;

  always_comb begin
    if (image_width_q == '0) begin
      eff_width = WIDTH_BITS'(1);
    end else if (image_width_q > WIDTH_BITS'(MAX_WIDTH)) begin
      eff_width = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      eff_width = image_width_q;
    end
    if (block_degree_q > DEGREE_BITS'(MAX_DEGREE)) begin
      eff_degree = DEGREE_BITS'(MAX_DEGREE);
    end else begin
      eff_degree = block_degree_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking and address of the partial sum
  // ---------------------------------------------------------------------------
  logic [POS_BITS-1:0]   col_q, row_q;
  logic [POS_BITS-1:0]   col_d, row_d;
  logic                  in_fire;

  logic [POS_BITS-1:0]   col_start, row_start;
  logic [WIDTH_BITS-1:0] row_wrap;
  logic [POS_BITS-1:0]   col_cur, row_cur;
  logic [WIDTH_BITS-1:0] coarse, covered;
  logic [POS_BITS-1:0]   side_mask;
  logic [POS_BITS-1:0]   cj, ci;
  logic                  s0_in_block, s0_first, s0_emit, s0_last;
  logic [WIDTH_BITS-1:0] col_inc, row_inc;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    col_start = frame_start_i ? '0 : col_q;
    row_start = frame_start_i ? '0 : row_q;

    // wrap a position left beyond the width by a register change
    if (WIDTH_BITS'(col_start) >= eff_width) begin
      col_cur  = '0;
      row_wrap = WIDTH_BITS'(row_start) + WIDTH_BITS'(1);
    end else begin
      col_cur  = col_start;
      row_wrap = WIDTH_BITS'(row_start);
    end
    row_cur = (row_wrap >= eff_width) ? '0 : row_wrap[POS_BITS-1:0];

    coarse    = eff_width >> eff_degree;
    covered   = coarse << eff_degree;
    side_mask = ~({POS_BITS{1'b1}} << eff_degree);
    cj        = col_cur >> eff_degree;
    ci        = row_cur >> eff_degree;

    s0_in_block = (WIDTH_BITS'(row_cur) < covered) && (WIDTH_BITS'(col_cur) < covered);
    s0_first    = ((row_cur & side_mask) == '0) && ((col_cur & side_mask) == '0);
    s0_emit     = s0_in_block && ((row_cur & side_mask) == side_mask)
                  && ((col_cur & side_mask) == side_mask);
    s0_last     = (WIDTH_BITS'(cj) == coarse - WIDTH_BITS'(1))
                  && (WIDTH_BITS'(ci) == coarse - WIDTH_BITS'(1));

    // advance to the next pixel
    col_inc = WIDTH_BITS'(col_cur) + WIDTH_BITS'(1);
    row_inc = WIDTH_BITS'(row_cur) + WIDTH_BITS'(1);
    if (col_inc >= eff_width) begin
      col_d = '0;
      row_d = (row_inc >= eff_width) ? '0 : row_inc[POS_BITS-1:0];
    end else begin
      col_d = col_inc[POS_BITS-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accumulate and write back
  // ---------------------------------------------------------------------------
  logic                   s1_valid_q;
  logic                   s1_wr_q, s1_first_q, s1_emit_q, s1_last_q;
  logic [POS_BITS-1:0]    s1_addr_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_adv;
  logic                   out_free;
  logic                   mem_we;

  logic [SUM_BITS-1:0]    line_mem [MAX_WIDTH];
  logic [SUM_BITS-1:0]    rd_data_q;

  logic                   fwd_valid_q;
  logic [POS_BITS-1:0]    fwd_addr_q;
  logic [SUM_BITS-1:0]    fwd_data_q;

  logic [SUM_BITS-1:0]    base_sum;
  logic [SUM_BITS-1:0]    new_sum;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = !s1_emit_q || out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign mem_we     = s1_valid_q && s1_wr_q && s1_adv;

  always_comb begin
    if (s1_first_q) begin
      base_sum = '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      // the read missed the write made at the same edge
      base_sum = fwd_data_q;
    end else begin
      base_sum = rd_data_q;
    end
    new_sum = base_sum + SUM_BITS'(s1_sample_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_addr_q] <= new_sum;
    end
    if (in_fire) begin
      rd_data_q <= line_mem[cj];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (!s1_valid_q || s1_adv) begin
        s1_valid_q <= in_fire;
      end
      if (mem_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_wr_q     <= s0_in_block;
      s1_first_q  <= s0_first;
      s1_emit_q   <= s0_emit;
      s1_last_q   <= s0_last;
      s1_addr_q   <= cj;
      s1_sample_q <= sample_i;
    end
    if (mem_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  logic [SUM_BITS-1:0] block_sum_q;
  logic                frame_last_q;
  logic                out_load;

  assign out_load = s1_valid_q && s1_emit_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      block_sum_q  <= new_sum;
      frame_last_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign block_sum_o  = block_sum_q;
  assign frame_last_o = frame_last_q;

endmodule

@@ sv/bsd_checker.sv @@
module bsd_checker
  import bsd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SUM_BITS-1:0]    block_sum_o,
  input logic                   frame_last_o,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [PADDR_BITS-1:0]  paddr,
  input logic [PDATA_BITS-1:0]  pwdata,
  input logic [PDATA_BITS-1:0]  prdata,
  input logic                   pready
);

  // held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(block_sum_o)
                                    && $stable(frame_last_o))
    else $error("held result changed");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // a new result follows a pixel transfer through stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a source pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // a written width reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
      |-> prdata[WIDTH_BITS-1:0] == $past(pwdata[WIDTH_BITS-1:0]))
    else $error("width readback mismatch");

endmodule

bind block_sum_downsampler bsd_checker u_bsd_checker (.*);
